// ----- rtl/pwrbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwrbd_pkg
// Shared types and constants of the pulse width RF bit decoder.
// ----------------------------------------------------------------------------
package pwrbd_pkg;

    localparam int unsigned TIME_W    = 16;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned KIND_W    = 2;
    localparam int unsigned PHASE_W   = 4;
    localparam int unsigned BITCNT_W  = 3;
    localparam int unsigned MAX_RES   = 3;
    localparam int unsigned RESCNT_W  = 2;
    localparam int unsigned PADDR_W   = 5;
    localparam int unsigned PDATA_W   = 32;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOST = 2'd0,
        KIND_SYNC = 2'd1,
        KIND_DATA = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        REG_ONE_MIN  = 3'd0,
        REG_ONE_MAX  = 3'd1,
        REG_ZERO_MIN = 3'd2,
        REG_ZERO_MAX = 3'd3,
        REG_GAP_MIN  = 3'd4,
        REG_GAP_MAX  = 3'd5
    } t_reg_idx;

    localparam logic [TIME_W-1:0]   RST_ONE_MIN  = 16'd250;
    localparam logic [TIME_W-1:0]   RST_ONE_MAX  = 16'd500;
    localparam logic [TIME_W-1:0]   RST_ZERO_MIN = 16'd650;
    localparam logic [TIME_W-1:0]   RST_ZERO_MAX = 16'd950;
    localparam logic [TIME_W-1:0]   RST_GAP_MIN  = 16'd150;
    localparam logic [TIME_W-1:0]   RST_GAP_MAX  = 16'd500;

    localparam logic [PHASE_W-1:0]  PHASE_FIRST_ZERO = 4'd4;
    localparam logic [PHASE_W-1:0]  PHASE_LAST_ZERO  = 4'd7;
    localparam logic [PHASE_W-1:0]  PHASE_SYNC       = 4'd8;
    localparam logic [BITCNT_W-1:0] BITCNT_LAST      = 3'd7;
    localparam logic [BYTE_W-1:0]   SYNC_BYTE_A      = 8'hE0;
    localparam logic [BYTE_W-1:0]   SYNC_BYTE_B      = 8'hF0;

    typedef struct packed {
        logic [TIME_W-1:0] one_min;
        logic [TIME_W-1:0] one_max;
        logic [TIME_W-1:0] zero_min;
        logic [TIME_W-1:0] zero_max;
        logic [TIME_W-1:0] gap_min;
        logic [TIME_W-1:0] gap_max;
    } t_cfg;

    typedef struct packed {
        logic [PHASE_W-1:0]  phase;
        logic [BYTE_W-1:0]   word;
        logic [BITCNT_W-1:0] count;
    } t_state;

    typedef struct packed {
        t_kind             kind;
        logic [BYTE_W-1:0] data;
        logic              last;
    } t_result;

    typedef struct packed {
        t_state                 state;
        logic [RESCNT_W-1:0]    count;
        t_result [MAX_RES-1:0]  res;
    } t_step;

endpackage

// ----- rtl/pulse_width_rf_bit_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_width_rf_bit_decoder
// On-off keyed pulse width decoder with sync detection and byte output.
// ----------------------------------------------------------------------------
// Each item is one edge with the interval since the previous edge. An item is
// registered and decoded, and its results (none, one or three) are loaded into a
// three-entry result register once it is empty or gives up its last result; it
// drains one result per cycle while i_ready is high. A new item is taken every
// cycle while edges cause at most one result and the output is not stalled; an
// edge that reaches sync holds the input until the last of its three results is taken.
// Timing windows are written through the APB port at byte addresses 0 to 20.
// ----------------------------------------------------------------------------
module pulse_width_rf_bit_decoder (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_edge_rising,
    input  logic [pwrbd_pkg::TIME_W-1:0]       i_interval_us,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [pwrbd_pkg::KIND_W-1:0]       o_event_kind,
    output logic [pwrbd_pkg::BYTE_W-1:0]       o_data_byte,
    output logic                               o_last_of_run,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pwrbd_pkg::PADDR_W-1:0]      paddr,
    input  logic [pwrbd_pkg::PDATA_W-1:0]      pwdata,
    output logic [pwrbd_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);
    import pwrbd_pkg::*;

    t_cfg                   r_cfg;
    t_state                 r_state;
    logic                   r_in_valid;
    logic                   r_in_rising;
    logic [TIME_W-1:0]      r_in_interval;
    t_result [MAX_RES-1:0]  r_res;
    logic [RESCNT_W-1:0]    r_res_cnt;

    t_step                  step;
    logic                   advance;
    logic                   pop;
    t_reg_idx               reg_idx;
    logic                   cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.one_min  <= RST_ONE_MIN;
            r_cfg.one_max  <= RST_ONE_MAX;
            r_cfg.zero_min <= RST_ZERO_MIN;
            r_cfg.zero_max <= RST_ZERO_MAX;
            r_cfg.gap_min  <= RST_GAP_MIN;
            r_cfg.gap_max  <= RST_GAP_MAX;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_ONE_MIN:  r_cfg.one_min  <= pwdata[TIME_W-1:0];
                REG_ONE_MAX:  r_cfg.one_max  <= pwdata[TIME_W-1:0];
                REG_ZERO_MIN: r_cfg.zero_min <= pwdata[TIME_W-1:0];
                REG_ZERO_MAX: r_cfg.zero_max <= pwdata[TIME_W-1:0];
                REG_GAP_MIN:  r_cfg.gap_min  <= pwdata[TIME_W-1:0];
                REG_GAP_MAX:  r_cfg.gap_max  <= pwdata[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_ONE_MIN:  prdata[TIME_W-1:0] = r_cfg.one_min;
            REG_ONE_MAX:  prdata[TIME_W-1:0] = r_cfg.one_max;
            REG_ZERO_MIN: prdata[TIME_W-1:0] = r_cfg.zero_min;
            REG_ZERO_MAX: prdata[TIME_W-1:0] = r_cfg.zero_max;
            REG_GAP_MIN:  prdata[TIME_W-1:0] = r_cfg.gap_min;
            REG_GAP_MAX:  prdata[TIME_W-1:0] = r_cfg.gap_max;
            default:      prdata = '0;
        endcase
    end

    pwrbd_decode u_decode (
        .i_cfg         (r_cfg),
        .i_state       (r_state),
        .i_edge_rising (r_in_rising),
        .i_interval_us (r_in_interval),
        .o_step        (step)
    );

    assign pop     = o_valid && i_ready;
    assign advance = r_in_valid && ((r_res_cnt == '0) || (r_res_cnt == 2'd1 && pop));
    assign o_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_rising   <= i_edge_rising;
            r_in_interval <= i_interval_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= step.state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_cnt <= '0;
        end else if (advance) begin
            r_res_cnt <= step.count;
        end else if (pop) begin
            r_res_cnt <= r_res_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= step.res;
        end else if (pop) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
        end
    end

    assign o_valid       = (r_res_cnt != '0);
    assign o_event_kind  = r_res[0].kind;
    assign o_data_byte   = r_res[0].data;
    assign o_last_of_run = r_res[0].last;

endmodule

// ----- rtl/pwrbd_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwrbd_decode
// Classifies one edge against the timing windows and computes the next
// decoder state together with the results the edge causes.
// ----------------------------------------------------------------------------
module pwrbd_decode (
    input  pwrbd_pkg::t_cfg                   i_cfg,
    input  pwrbd_pkg::t_state                 i_state,
    input  logic                              i_edge_rising,
    input  logic [pwrbd_pkg::TIME_W-1:0]      i_interval_us,
    output pwrbd_pkg::t_step                  o_step
);
    import pwrbd_pkg::*;

    logic              in_one;
    logic              in_zero;
    logic              gap_ok;
    logic              do_reset;
    logic              do_bit;
    logic              bit_val;
    logic              do_sync;
    logic [BYTE_W-1:0] shifted;

    assign in_one  = (i_interval_us >= i_cfg.one_min)  && (i_interval_us <= i_cfg.one_max);
    assign in_zero = (i_interval_us >= i_cfg.zero_min) && (i_interval_us <= i_cfg.zero_max);
    assign gap_ok  = (i_interval_us >= i_cfg.gap_min)  && (i_interval_us <= i_cfg.gap_max);
    assign shifted = {i_state.word[BYTE_W-2:0], bit_val};

    always_comb begin
        do_reset = 1'b0;
        do_bit   = 1'b0;
        bit_val  = 1'b0;
        do_sync  = 1'b0;
        o_step   = '0;
        o_step.state = i_state;

        if (i_edge_rising) begin
            do_reset = !gap_ok;
        end else if (in_one) begin
            if (i_state.phase == PHASE_SYNC) begin
                do_bit  = 1'b1;
                bit_val = 1'b1;
            end else if (i_state.phase < PHASE_FIRST_ZERO) begin
                o_step.state.phase = i_state.phase + 1'b1;
            end else begin
                do_reset = 1'b1;
            end
        end else if (in_zero) begin
            if (i_state.phase == PHASE_SYNC) begin
                do_bit = 1'b1;
            end else if (i_state.phase >= PHASE_FIRST_ZERO && i_state.phase < PHASE_SYNC) begin
                o_step.state.phase = i_state.phase + 1'b1;
                do_sync = (i_state.phase == PHASE_LAST_ZERO);
            end else begin
                do_reset = 1'b1;
            end
        end else begin
            do_reset = 1'b1;
        end

        if (do_reset) begin
            o_step.state = '0;
            if (i_state.phase == PHASE_SYNC) begin
                o_step.count       = 2'd1;
                o_step.res[0].kind = KIND_LOST;
                o_step.res[0].last = 1'b1;
            end
        end

        if (do_bit) begin
            if (i_state.count == BITCNT_LAST) begin
                o_step.state.word  = '0;
                o_step.state.count = '0;
                o_step.count       = 2'd1;
                o_step.res[0].kind = KIND_DATA;
                o_step.res[0].data = shifted;
                o_step.res[0].last = 1'b1;
            end else begin
                o_step.state.word  = shifted;
                o_step.state.count = i_state.count + 1'b1;
            end
        end

        if (do_sync) begin
            o_step.count       = 2'd3;
            o_step.res[0].kind = KIND_SYNC;
            o_step.res[1].kind = KIND_DATA;
            o_step.res[1].data = SYNC_BYTE_A;
            o_step.res[2].kind = KIND_DATA;
            o_step.res[2].data = SYNC_BYTE_B;
            o_step.res[2].last = 1'b1;
        end
    end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pulse width RF bit decoder.
// ----------------------------------------------------------------------------
// Edge items go in through the valid/ready input, and decoded events are taken
// at the output under random stalls on both sides. A tracker class keeps its
// own copy of the timing windows and of the sync, shift and bit count state.
// It predicts the events of every accepted edge and compares each event that
// comes out, field by field, in order. A directed opening covers the field
// extremes and the sync and reset cases. Random frames with noise and broken
// preambles then run under several window settings, which are written over
// APB while the decoder is idle.
// ----------------------------------------------------------------------------
module testbench;
    import pwrbd_pkg::*;

    localparam int unsigned STALL_LIMIT   = 2000;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam logic [PADDR_W-1:0] ADDR_UNUSED = 5'd24;

    class decode_tracker;
        logic [TIME_W-1:0]  one_min, one_max, zero_min, zero_max, gap_min, gap_max;
        logic [PHASE_W-1:0] phase;
        logic [BYTE_W-1:0]  word;
        logic [3:0]         nbits;
        t_result            expected_events[$];
        int                 mismatches, edges, events, syncs, byte_events, losses;

        function new();
            one_min  = RST_ONE_MIN;
            one_max  = RST_ONE_MAX;
            zero_min = RST_ZERO_MIN;
            zero_max = RST_ZERO_MAX;
            gap_min  = RST_GAP_MIN;
            gap_max  = RST_GAP_MAX;
            phase = '0;
            word  = '0;
            nbits = '0;
            mismatches = 0;
            edges = 0;
            events = 0;
            syncs = 0;
            byte_events = 0;
            losses = 0;
        endfunction

        function void set_window(t_reg_idx idx, logic [TIME_W-1:0] value);
            case (idx)
                REG_ONE_MIN:  one_min  = value;
                REG_ONE_MAX:  one_max  = value;
                REG_ZERO_MIN: zero_min = value;
                REG_ZERO_MAX: zero_max = value;
                REG_GAP_MIN:  gap_min  = value;
                REG_GAP_MAX:  gap_max  = value;
                default: ;
            endcase
        endfunction

        function void push_event(t_kind kind, logic [BYTE_W-1:0] data);
            t_result r;
            r.kind = kind;
            r.data = data;
            r.last = 1'b0;
            expected_events.push_back(r);
        endfunction

        function void restart();
            if (phase == PHASE_SYNC) push_event(KIND_LOST, '0);
            phase = '0;
            word  = '0;
            nbits = '0;
        endfunction

        function void shift_bit(logic b);
            word  = {word[BYTE_W-2:0], b};
            nbits = nbits + 1'b1;
            if (nbits == 4'd8) begin
                push_event(KIND_DATA, word);
                word  = '0;
                nbits = '0;
            end
        endfunction

        function void note_edge(logic rising, logic [TIME_W-1:0] t);
            int      queued;
            t_result r;
            queued = expected_events.size();
            edges++;
            if (rising) begin
                if (t > gap_max || t < gap_min) restart();
            end else if (t >= one_min && t <= one_max) begin
                if (phase == PHASE_SYNC) shift_bit(1'b1);
                else if (phase < PHASE_FIRST_ZERO) phase = phase + 1'b1;
                else restart();
            end else if (t >= zero_min && t <= zero_max) begin
                if (phase == PHASE_SYNC) begin
                    shift_bit(1'b0);
                end else if (phase >= PHASE_FIRST_ZERO) begin
                    phase = phase + 1'b1;
                    if (phase == PHASE_SYNC) begin
                        push_event(KIND_SYNC, '0);
                        push_event(KIND_DATA, SYNC_BYTE_A);
                        push_event(KIND_DATA, SYNC_BYTE_B);
                    end
                end else begin
                    restart();
                end
            end else begin
                restart();
            end
            if (expected_events.size() > queued) begin
                r = expected_events.pop_back();
                r.last = 1'b1;
                expected_events.push_back(r);
            end
        endfunction

        function void check_event(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] data,
                                  logic last);
            t_result want;
            if (expected_events.size() == 0) begin
                $error("Unexpected event: event_kind %0d, data_byte 0x%02h, last_of_run %0b",
                       kind, data, last);
                mismatches++;
                return;
            end
            want = expected_events.pop_front();
            events++;
            if (want.kind !== kind) begin
                $error("event_kind: expected %0d, got %0d", want.kind, kind);
                mismatches++;
            end
            if (want.data !== data) begin
                $error("data_byte: expected 0x%02h, got 0x%02h", want.data, data);
                mismatches++;
            end
            if (want.last !== last) begin
                $error("last_of_run: expected %0b, got %0b", want.last, last);
                mismatches++;
            end
            case (want.kind)
                KIND_SYNC: syncs++;
                KIND_DATA: byte_events++;
                KIND_LOST: losses++;
                default: ;
            endcase
        endfunction
    endclass

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic               i_edge_rising = 1'b0;
    logic [TIME_W-1:0]  i_interval_us = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [KIND_W-1:0]  o_event_kind;
    logic [BYTE_W-1:0]  o_data_byte;
    logic               o_last_of_run;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    decode_tracker tracker;
    int send_idle_pct = 12;
    int recv_idle_pct = 69;
    int sent_edges = 0;
    int stall_cycles = 0;

    pulse_width_rf_bit_decoder dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) i_ready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && o_ready) tracker.note_edge(i_edge_rising, i_interval_us);
        if (i_rst_n && o_valid && i_ready)
            tracker.check_event(o_event_kind, o_data_byte, o_last_of_run);
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    function automatic logic [TIME_W-1:0] pick_in(logic [TIME_W-1:0] lo,
                                                   logic [TIME_W-1:0] hi);
        if (lo > hi) return TIME_W'($urandom);
        return TIME_W'($urandom_range(hi, lo));
    endfunction

    function automatic logic [TIME_W-1:0] pick_zero();
        logic [TIME_W-1:0] lo;
        lo = tracker.zero_min;
        if (tracker.one_min <= tracker.one_max && tracker.one_max < tracker.zero_max &&
            tracker.one_max >= lo) lo = tracker.one_max + 1'b1;
        return pick_in(lo, tracker.zero_max);
    endfunction

    function automatic logic [TIME_W-1:0] bad_gap();
        if (tracker.gap_min > 0 && $urandom_range(1))
            return pick_in('0, tracker.gap_min - 1'b1);
        if (tracker.gap_max < 16'hFFFF) return pick_in(tracker.gap_max + 1'b1, 16'hFFFF);
        return TIME_W'($urandom);
    endfunction

    task automatic send_edge(logic rising, logic [TIME_W-1:0] t);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_edge_rising <= rising;
        i_interval_us <= t;
        sent_edges++;
        do @(posedge i_clk); while (o_ready !== 1'b1);
    endtask

    task automatic send_bit(logic one);
        if ($urandom_range(9) < 8) send_edge(1'b1, pick_in(tracker.gap_min, tracker.gap_max));
        send_edge(1'b0, one ? pick_in(tracker.one_min, tracker.one_max) : pick_zero());
    endtask

    task automatic run_frames(int target);
        int stop_at;
        int kind_pick;
        int n;
        stop_at = sent_edges + target;
        while (sent_edges < stop_at) begin
            kind_pick = $urandom_range(99);
            if (kind_pick < 70) begin
                repeat (4) send_bit(1'b1);
                repeat (4) send_bit(1'b0);
                repeat ($urandom_range(40, 1)) send_bit(1'($urandom_range(1)));
                if ($urandom_range(1)) send_edge(1'($urandom_range(1)), TIME_W'($urandom));
            end else if (kind_pick < 88) begin
                n = $urandom_range(7);
                for (int i = 0; i < n; i++) send_bit(i < 4);
                if ($urandom_range(1)) begin
                    send_bit(n >= 4);
                end else begin
                    send_edge(1'b1, bad_gap());
                end
            end else begin
                repeat ($urandom_range(5, 1))
                    send_edge(1'($urandom_range(1)), TIME_W'($urandom));
            end
        end
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.expected_events.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(logic [PADDR_W-1:0] addr, logic [TIME_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= PDATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic write_window(t_reg_idx idx, logic [TIME_W-1:0] value);
        apb_write({idx, 2'b00}, value);
        tracker.set_window(idx, value);
    endtask

    task automatic set_windows(logic [TIME_W-1:0] one_lo, logic [TIME_W-1:0] one_hi,
                               logic [TIME_W-1:0] zero_lo, logic [TIME_W-1:0] zero_hi,
                               logic [TIME_W-1:0] gap_lo, logic [TIME_W-1:0] gap_hi);
        write_window(REG_ONE_MIN, one_lo);
        write_window(REG_ONE_MAX, one_hi);
        write_window(REG_ZERO_MIN, zero_lo);
        write_window(REG_ZERO_MAX, zero_hi);
        write_window(REG_GAP_MIN, gap_lo);
        write_window(REG_GAP_MAX, gap_hi);
    endtask

    task automatic random_windows();
        logic [TIME_W-1:0] a, b, c;
        a = TIME_W'($urandom_range(3000));
        b = a + TIME_W'($urandom_range(800));
        c = b + TIME_W'($urandom_range(600, 1));
        set_windows(a, b, c, c + TIME_W'($urandom_range(800)), TIME_W'($urandom_range(400)),
                    TIME_W'(400 + $urandom_range(3000)));
    endtask

    initial begin
        while (stall_cycles < STALL_LIMIT) @(posedge i_clk);
        $display("Watchdog: no item moved for %0d cycles.", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        logic [BYTE_W-1:0] directed_byte;
        tracker = new();
        directed_byte = 8'hB2;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset windows: one 250..500, zero 650..950, gap 150..500.
        send_edge(1'b1, 16'hFFFF);
        send_edge(1'b0, 16'h0000);
        send_edge(1'b0, 16'd650);
        send_edge(1'b1, 16'd149);
        send_edge(1'b0, 16'd250);
        send_edge(1'b0, 16'd500);
        send_edge(1'b0, 16'd251);
        send_edge(1'b0, 16'd499);
        send_edge(1'b0, 16'd400);
        repeat (4) send_edge(1'b0, 16'd300);
        send_edge(1'b0, 16'd650);
        send_edge(1'b0, 16'd950);
        send_edge(1'b1, 16'd150);
        send_edge(1'b0, 16'd651);
        send_edge(1'b1, 16'd500);
        send_edge(1'b0, 16'd949);
        for (int i = BYTE_W - 1; i >= 0; i--)
            send_edge(1'b0, directed_byte[i] ? 16'd375 : 16'd800);
        send_edge(1'b0, 16'd649);
        hold_until_drained();

        // Overlapping one and zero windows, gap window wide open.
        set_windows(16'd100, 16'd700, 16'd600, 16'd1200, 16'd0, 16'hFFFF);
        apb_write(ADDR_UNUSED, 16'd7);
        run_frames(25);
        hold_until_drained();
        run_frames(25);
        hold_until_drained();

        send_idle_pct = 69;
        recv_idle_pct = 12;
        // Single-value one and zero windows at both ends of the interval range.
        set_windows(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd1, 16'hFFFE);
        run_frames(20);
        hold_until_drained();
        run_frames(20);
        hold_until_drained();
        // Empty one and gap windows with a zero window that takes everything.
        set_windows(16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0);
        run_frames(10);
        hold_until_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) begin
            random_windows();
            run_frames(25);
            hold_until_drained();
        end

        repeat (20) @(posedge i_clk);
        $display("Run checked %0d edge items and %0d decoded events under six window settings.",
                 tracker.edges, tracker.events);
        $display("Events: %0d sync found, %0d data bytes, %0d sync lost.",
                 tracker.syncs, tracker.byte_events, tracker.losses);
        if (tracker.mismatches == 0 && tracker.expected_events.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
